FILE: sv/assert_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define GR_ASSERT_IMP(lbl, ck, rs, a, c) \
   lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, gated off during reset.
`define GR_ASSERT_NXT(lbl, ck, rs, a, c) \
   lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/gr2x_pkg.sv
`default_nettype none
package gr2x_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int PIXEL_BITS  = 16;
   localparam int SIZE_BITS   = 13;
   localparam int COL_BITS    = 12;
   localparam int ROW_BITS    = 12;
   localparam int OUT_BITS    = 11;
   localparam int STORE_ROWS  = 5;
   localparam int SLOT_BITS   = 3;
   localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
   localparam int WT_BITS     = 6;
   localparam int WSUM_BITS   = 9;
   localparam int ACC_BITS    = 25;
   localparam int NUM_BITS    = 25;
   localparam int DEN_BITS    = WSUM_BITS + 1;
   localparam int DIVC_BITS   = 5;
   localparam int TAP_BITS    = 3;
   localparam int CSR_IDX_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_SRC_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SRC_HEIGHT = 8'd1;

   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd480;

   // Controller to datapath commands.
   typedef struct packed {
      logic                accept;
      logic                clear;
      logic                issue;
      logic [TAP_BITS-1:0] tap_kx;
      logic [TAP_BITS-1:0] tap_ky;
      logic                oxi;
      logic                oyi;
      logic                div_start;
      logic                div_step;
      logic                emit;
      logic                last_run;
   } ctl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [1:0] nx;
      logic [1:0] ny;
      logic       rsp_free;
   } ctl_sts_type;

   // 1-4-6-4-1 binomial tap weight.
   function automatic logic [2:0] tap_wt(input logic [TAP_BITS-1:0] k);
      logic [2:0] w;
      case (k)
         3'd0:    w = 3'd1;
         3'd1:    w = 3'd4;
         3'd2:    w = 3'd6;
         3'd3:    w = 3'd4;
         3'd4:    w = 3'd1;
         default: w = 3'd0;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

FILE: sv/gr2x_ifs.sv
`default_nettype none
interface gr2x_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gr2x_pkg::PIXEL_BITS-1:0] pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gr2x_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gr2x_pkg::PIXEL_BITS-1:0] pixel_out;
   logic [gr2x_pkg::OUT_BITS-1:0]        out_x;
   logic [gr2x_pkg::OUT_BITS-1:0]        out_y;
   logic                                 last_in_run;
   logic                                 last_of_frame;
   modport source (output valid, output pixel_out, output out_x, output out_y,
                   output last_in_run, output last_of_frame, input ready);
   modport sink   (input valid, input pixel_out, input out_x, input out_y,
                   input last_in_run, input last_of_frame, output ready);
endinterface

interface gr2x_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [gr2x_pkg::CSR_IDX_BITS-1:0]    index;
   logic [gr2x_pkg::SIZE_BITS-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/gaussian_reduce_2x_5tap.sv
// A result is valid after its input word passes the check, 25 tap reads, a drain,
// the divide load, a 25-step divide and the emit.
// A new input word is taken only once the sequencer is idle again; the tap loop on the
// single line-store read port and the bit-serial divider set the rate.
// Reset (synchronous, active high) clears the raster position, loads 640x480 and idles
// the sequencer; the line store is not cleared.
`default_nettype none
module gaussian_reduce_2x_5tap (
   input  wire logic clock,
   input  wire logic reset,
   gr2x_req_if.sink   req_ch,
   gr2x_rsp_if.source rsp_ch,
   gr2x_csr_if.sink   csr_ch
);
   gr2x_pkg::ctl_cmd_type cmd;
   gr2x_pkg::ctl_sts_type sts;

   assign csr_ch.ready = 1'b1;

   gr2x_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   gr2x_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .pixel_in         (req_ch.pixel_in),
      .csr_valid        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_pixel_out    (rsp_ch.pixel_out),
      .rsp_out_x        (rsp_ch.out_x),
      .rsp_out_y        (rsp_ch.out_y),
      .rsp_last_in_run  (rsp_ch.last_in_run),
      .rsp_last_of_frame(rsp_ch.last_of_frame)
   );
endmodule
`default_nettype wire

FILE: sv/gr2x_ram.sv
`default_nettype none
module gr2x_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: sv/gr2x_ctrl.sv
`default_nettype none
module gr2x_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire gr2x_pkg::ctl_sts_type sts,
   output gr2x_pkg::ctl_cmd_type      cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_TAPS  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DLOAD = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   localparam logic [gr2x_pkg::TAP_BITS-1:0]  TAP_LAST = 3'd4;
   localparam logic [gr2x_pkg::DIVC_BITS-1:0] DIV_LAST =
      gr2x_pkg::DIVC_BITS'(gr2x_pkg::NUM_BITS - 1);

   logic [2:0] state_ff, state_in;
   logic [gr2x_pkg::TAP_BITS-1:0] kx_ff, kx_in, ky_ff, ky_in;
   logic oxi_ff, oxi_in, oyi_ff, oyi_in;
   logic [gr2x_pkg::DIVC_BITS-1:0] divc_ff, divc_in;
   logic x_done, y_done;

   assign x_done = ({1'b0, oxi_ff} + 2'd1) == sts.nx;
   assign y_done = ({1'b0, oyi_ff} + 2'd1) == sts.ny;
   assign req_ready = (state_ff == S_IDLE);

   // sequence one input: store, then filter each completed window
   always_comb begin
      state_in = state_ff;
      kx_in    = kx_ff;
      ky_in    = ky_ff;
      oxi_in   = oxi_ff;
      oyi_in   = oyi_ff;
      divc_in  = divc_ff;
      cmd      = '0;
      cmd.tap_kx   = kx_ff;
      cmd.tap_ky   = ky_ff;
      cmd.oxi      = oxi_ff;
      cmd.oyi      = oyi_ff;
      cmd.last_run = x_done && y_done;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.nx == 2'd0 || sts.ny == 2'd0) begin
               state_in = S_IDLE;
            end else begin
               cmd.clear = 1'b1;
               oxi_in    = 1'b0;
               oyi_in    = 1'b0;
               kx_in     = '0;
               ky_in     = '0;
               state_in  = S_TAPS;
            end
         end
         S_TAPS: begin
            cmd.issue = 1'b1;
            if (kx_ff == TAP_LAST) begin
               kx_in = '0;
               if (ky_ff == TAP_LAST) begin
                  ky_in    = '0;
                  state_in = S_DRAIN;
               end else begin
                  ky_in = ky_ff + 3'd1;
               end
            end else begin
               kx_in = kx_ff + 3'd1;
            end
         end
         S_DRAIN: begin
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_start = 1'b1;
            divc_in       = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            divc_in      = divc_ff + 5'd1;
            if (divc_ff == DIV_LAST) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               if (x_done && y_done) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.clear = 1'b1;
                  if (x_done) begin
                     oxi_in = 1'b0;
                     oyi_in = 1'b1;
                  end else begin
                     oxi_in = 1'b1;
                  end
                  state_in = S_TAPS;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kx_ff    <= '0;
         ky_ff    <= '0;
         oxi_ff   <= 1'b0;
         oyi_ff   <= 1'b0;
         divc_ff  <= '0;
      end else begin
         state_ff <= state_in;
         kx_ff    <= kx_in;
         ky_ff    <= ky_in;
         oxi_ff   <= oxi_in;
         oyi_ff   <= oyi_in;
         divc_ff  <= divc_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/gr2x_datapath.sv
`default_nettype none
module gr2x_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire gr2x_pkg::ctl_cmd_type                  cmd,
   output gr2x_pkg::ctl_sts_type                       sts,
   input  wire logic signed [gr2x_pkg::PIXEL_BITS-1:0] pixel_in,
   input  wire logic                                   csr_valid,
   input  wire logic [gr2x_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire logic [gr2x_pkg::SIZE_BITS-1:0]         csr_data,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_valid,
   output logic signed [gr2x_pkg::PIXEL_BITS-1:0]      rsp_pixel_out,
   output logic [gr2x_pkg::OUT_BITS-1:0]               rsp_out_x,
   output logic [gr2x_pkg::OUT_BITS-1:0]               rsp_out_y,
   output logic                                        rsp_last_in_run,
   output logic                                        rsp_last_of_frame
);
   localparam int SB = gr2x_pkg::SIZE_BITS;
   localparam int CB = gr2x_pkg::COL_BITS;
   localparam int OB = gr2x_pkg::OUT_BITS;

   logic [SB-1:0] src_width_ff, src_height_ff, w_eff, h_eff;
   logic [CB-1:0] col_ff, col_in, row_ff, row_in, c_cur, r_cur;
   logic [gr2x_pkg::SLOT_BITS-1:0] slot_ff, slot_in, slot_cur;
   logic wrap, csr_wr;
   logic [SB-1:0] c_next, r_next;

   logic [CB-1:0] cur_r_ff;
   logic [gr2x_pkg::SLOT_BITS-1:0] cur_slot_ff;
   logic [OB-1:0] xa_ff, ya_ff;
   logic [1:0] nx_ff, ny_ff;
   logic [SB-1:0] xrange, yrange;

   // clamp the size registers into range
   assign w_eff = (src_width_ff == '0) ? 13'd1 :
                  (src_width_ff > SB'(gr2x_pkg::MAX_WIDTH)) ? SB'(gr2x_pkg::MAX_WIDTH) :
                  src_width_ff;
   assign h_eff = (src_height_ff == '0) ? 13'd1 :
                  (src_height_ff > SB'(gr2x_pkg::MAX_HEIGHT)) ? SB'(gr2x_pkg::MAX_HEIGHT) :
                  src_height_ff;

   assign wrap     = ({1'b0, col_ff} >= w_eff) || ({1'b0, row_ff} >= h_eff);
   assign c_cur    = wrap ? '0 : col_ff;
   assign r_cur    = wrap ? '0 : row_ff;
   assign slot_cur = wrap ? '0 : slot_ff;
   assign c_next   = {1'b0, c_cur} + 13'd1;
   assign r_next   = {1'b0, r_cur} + 13'd1;
   assign csr_wr   = csr_valid &&
                     (csr_index == gr2x_pkg::REG_SRC_WIDTH ||
                      csr_index == gr2x_pkg::REG_SRC_HEIGHT);

   // output indexes along one axis whose window closes at pos: {first, count}
   function automatic logic [SB-1:0] axis_range(input logic [CB-1:0] pos,
                                                 input logic [SB-1:0] size);
      logic [SB-1:0] lo, hi, cnt;
      lo  = '0;
      hi  = '0;
      cnt = '0;
      if ({1'b0, pos} == size - 13'd1) begin
         lo  = (size >= 13'd3) ? ((size - 13'd2) >> 1) : 13'd0;
         hi  = (size - 13'd1) >> 1;
         cnt = hi - lo + 13'd1;
      end else if (!pos[0] && pos >= 12'd2) begin
         lo  = ({1'b0, pos} >> 1) - 13'd1;
         cnt = 13'd1;
      end
      return {lo[OB-1:0], cnt[1:0]};
   endfunction

   assign xrange = axis_range(c_cur, w_eff);
   assign yrange = axis_range(r_cur, h_eff);

   // advance the raster position on each word; a size register write returns it to the origin
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (csr_wr) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = '0;
      end else if (cmd.accept) begin
         if (c_next >= w_eff) begin
            col_in = '0;
            if (r_next >= h_eff) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = r_next[CB-1:0];
               slot_in = (slot_cur == 3'd4) ? 3'd0 : slot_cur + 3'd1;
            end
         end else begin
            col_in  = c_next[CB-1:0];
            row_in  = r_cur;
            slot_in = slot_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= gr2x_pkg::RESET_WIDTH;
         src_height_ff <= gr2x_pkg::RESET_HEIGHT;
         col_ff        <= '0;
         row_ff        <= '0;
         slot_ff       <= '0;
      end else begin
         if (csr_valid && csr_index == gr2x_pkg::REG_SRC_WIDTH) begin
            src_width_ff <= csr_data;
         end
         if (csr_valid && csr_index == gr2x_pkg::REG_SRC_HEIGHT) begin
            src_height_ff <= csr_data;
         end
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // latch the position of the word in work
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_r_ff    <= r_cur;
         cur_slot_ff <= slot_cur;
         xa_ff       <= xrange[SB-1:2];
         nx_ff       <= xrange[1:0];
         ya_ff       <= yrange[SB-1:2];
         ny_ff       <= yrange[1:0];
      end
   end

   // tap address: row slot and column of one window position
   logic [OB-1:0] ox, oy;
   logic [13:0] s_x, s_y, sx, sy;
   logic x_ok, y_ok, tap_ok;
   logic [2:0] row_back;
   logic [3:0] slot_t;
   logic [gr2x_pkg::SLOT_BITS-1:0] tap_slot;
   logic [gr2x_pkg::ADDR_BITS-1:0] wr_addr, rd_addr;
   logic signed [gr2x_pkg::PIXEL_BITS-1:0] rd_data;

   assign ox   = xa_ff + {{(OB-1){1'b0}}, cmd.oxi};
   assign oy   = ya_ff + {{(OB-1){1'b0}}, cmd.oyi};
   assign s_x  = {2'b00, ox, 1'b0} + {11'd0, cmd.tap_kx};
   assign s_y  = {2'b00, oy, 1'b0} + {11'd0, cmd.tap_ky};
   assign sx   = s_x - 14'd2;
   assign sy   = s_y - 14'd2;
   assign x_ok = (s_x >= 14'd2) && (sx < {1'b0, w_eff});
   assign y_ok = (s_y >= 14'd2) && (sy < {1'b0, h_eff});
   assign tap_ok = x_ok && y_ok;
   assign row_back = cur_r_ff[2:0] - sy[2:0];
   assign slot_t = {1'b0, cur_slot_ff} - {1'b0, row_back};
   assign tap_slot = slot_t[3] ? slot_t[2:0] + 3'd5 : slot_t[2:0];
   assign wr_addr  = {slot_cur, c_cur};
   assign rd_addr  = tap_ok ? {tap_slot, sx[CB-1:0]} : '0;

   gr2x_ram #(
      .WIDTH(gr2x_pkg::PIXEL_BITS),
      .DEPTH(gr2x_pkg::STORE_DEPTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (cmd.accept),
      .wr_addr(wr_addr),
      .wr_data(pixel_in),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // weight the tap that returns from the store and accumulate
   logic tap_vld_ff;
   logic [gr2x_pkg::WT_BITS-1:0] wt_ff;
   logic signed [gr2x_pkg::ACC_BITS-1:0] acc_ff;
   logic [gr2x_pkg::WSUM_BITS-1:0] wsum_ff;
   logic signed [22:0] prod;

   assign prod = rd_data * $signed({1'b0, wt_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff <= 1'b0;
      end else begin
         tap_vld_ff <= cmd.issue && tap_ok;
      end
   end

   always_ff @(posedge clock) begin
      wt_ff <= gr2x_pkg::tap_wt(cmd.tap_kx) * gr2x_pkg::tap_wt(cmd.tap_ky);
      if (cmd.clear) begin
         acc_ff  <= '0;
         wsum_ff <= '0;
      end else if (tap_vld_ff) begin
         acc_ff  <= acc_ff + gr2x_pkg::ACC_BITS'(prod);
         wsum_ff <= wsum_ff + {3'd0, wt_ff};
      end
   end

   // restoring divide, one quotient bit a cycle: (2|acc| + wsum) / (2 wsum)
   logic [gr2x_pkg::NUM_BITS-1:0] mag, q_ff;
   logic [gr2x_pkg::DEN_BITS-1:0] den_ff, rem_ff;
   logic [gr2x_pkg::DEN_BITS:0] trial;
   logic neg_ff;

   assign mag   = acc_ff[gr2x_pkg::ACC_BITS-1] ? gr2x_pkg::NUM_BITS'(-acc_ff)
                                               : gr2x_pkg::NUM_BITS'(acc_ff);
   assign trial = {rem_ff, q_ff[gr2x_pkg::NUM_BITS-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         q_ff   <= {mag[gr2x_pkg::NUM_BITS-2:0], 1'b0} +
                   {{(gr2x_pkg::NUM_BITS-gr2x_pkg::WSUM_BITS){1'b0}}, wsum_ff};
         den_ff <= {wsum_ff, 1'b0};
         rem_ff <= '0;
         neg_ff <= acc_ff[gr2x_pkg::ACC_BITS-1];
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= gr2x_pkg::DEN_BITS'(trial - {1'b0, den_ff});
            q_ff   <= {q_ff[gr2x_pkg::NUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[gr2x_pkg::DEN_BITS-1:0];
            q_ff   <= {q_ff[gr2x_pkg::NUM_BITS-2:0], 1'b0};
         end
      end
   end

   // result register: load on emit, drop when taken
   logic [SB-1:0] ow_m1, oh_m1;
   logic [gr2x_pkg::PIXEL_BITS-1:0] qlo;
   assign ow_m1 = (w_eff - 13'd1) >> 1;
   assign oh_m1 = (h_eff - 13'd1) >> 1;
   assign qlo   = q_ff[gr2x_pkg::PIXEL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pixel_out     <= neg_ff ? $signed(-qlo) : $signed(qlo);
         rsp_out_x         <= ox;
         rsp_out_y         <= oy;
         rsp_last_in_run   <= cmd.last_run;
         rsp_last_of_frame <= (ox == ow_m1[OB-1:0]) && (oy == oh_m1[OB-1:0]);
      end
   end

   assign sts.nx       = nx_ff;
   assign sts.ny       = ny_ff;
   assign sts.rsp_free = !rsp_valid || rsp_ready;
endmodule
`default_nettype wire

FILE: sv/gr2x_checker.sv
`default_nettype none
`include "assert_macros.svh"
module gr2x_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_pixel_out,
   input wire logic        rsp_last_in_run,
   input wire logic        rsp_last_of_frame,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);
   // hold a stalled result word
   `GR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_out))
   // one word in work at a time: no accept on the following edge
   `GR_ASSERT_NXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready)
   // the frame's last result closes its run
   `GR_ASSERT_IMP(a_frame_run, clock, reset, rsp_valid && rsp_last_of_frame, rsp_last_in_run)
   // register writes never stall
   `GR_ASSERT_IMP(a_csr_ready, clock, reset, csr_valid, csr_ready)
endmodule

bind gaussian_reduce_2x_5tap gr2x_checker u_gr2x_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_pixel_out    (rsp_ch.pixel_out),
   .rsp_last_in_run  (rsp_ch.last_in_run),
   .rsp_last_of_frame(rsp_ch.last_of_frame),
   .csr_valid        (csr_ch.valid),
   .csr_ready        (csr_ch.ready)
);
`default_nettype wire
